FILE: src/selective_repeat_receiver_defines.svh
// Assertion macros shared by the selective-repeat receiver RTL.
`ifndef SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// Invariant checked at every clock edge outside reset.
`define SRR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// Same-cycle implication checked outside reset.
`define SRR_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SRR_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define SRR_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

FILE: src/srr_pkg.sv
// Shared constants for the selective-repeat receiver.
`default_nettype none

package srr_pkg;

  localparam int DEPTH   = 256;
  localparam int FRAME_W = 8;
  localparam int REPLY_W = 9;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int BASE_W  = $clog2(DEPTH + 1);
  localparam int CMP_W   = (BASE_W > FRAME_W) ? BASE_W : FRAME_W;

  localparam logic REPLY_ACK  = 1'b0;
  localparam logic REPLY_NACK = 1'b1;

endpackage

`default_nettype wire

FILE: src/selective_repeat_receiver.sv
// Selective-repeat receiver: bitmap RAM, window base tracking and reply register.
// A stale frame is dropped in ST_IDLE; a frame above the base is looked up in the bitmap
// (ST_CHECK) and may post a NACK; an in-order frame walks the base past buffered frames
// in ST_WALK, one RAM read each, and skips the walk when the base reaches DEPTH.
// Each reply waits in ST_REPLY while out_stall holds; in_stall is high outside ST_IDLE.
// Reset (rst, synchronous): set base to 1, clear NACK state, sweep the bitmap in ST_CLEAR.
`default_nettype none
`include "selective_repeat_receiver_defines.svh"

module selective_repeat_receiver
  import srr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [FRAME_W-1:0] frame_number,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    reply_kind,
  output logic      [REPLY_W-1:0] reply_number
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_REPLY
  } state_t;

  localparam logic [BASE_W-1:0] DEPTH_B = BASE_W'(DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DEPTH - 1);

  // Registers
  state_t               state, state_next;
  logic [BASE_W-1:0]    window_base, window_base_next;
  logic [BASE_W-1:0]    nacked_base, nacked_base_next;
  logic [FRAME_W-1:0]   frame_q, frame_q_next;
  logic                 pend_kind, pend_kind_next;
  logic [REPLY_W-1:0]   pend_num, pend_num_next;
  logic [ADDR_W-1:0]    clr_idx, clr_idx_next;

  // Bitmap RAM ports
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic                 mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic                 mem_rdata;

  logic [BASE_W-1:0]    base_inc;
  logic [CMP_W-1:0]     frame_x;
  logic [CMP_W-1:0]     base_x;
  logic                 slot_free;

  assign base_inc  = window_base + BASE_W'(1);
  assign frame_x   = CMP_W'(frame_number);
  assign base_x    = CMP_W'(window_base);
  // The reply register can take a new transaction when empty or draining this cycle.
  assign slot_free = !out_valid || !out_stall;

  srr_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH   (1),
    .AW      (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next       = state;
    window_base_next = window_base;
    nacked_base_next = nacked_base;
    frame_q_next     = frame_q;
    pend_kind_next   = pend_kind;
    pend_num_next    = pend_num;
    clr_idx_next     = clr_idx;
    mem_we           = 1'b0;
    mem_waddr        = clr_idx;
    mem_wdata        = 1'b1;
    mem_raddr        = ADDR_W'(base_inc);
    in_stall         = (state != ST_IDLE);

    case (state)
      ST_CLEAR: begin
        // Sweep the bitmap, one entry per cycle.
        mem_we       = 1'b1;
        mem_wdata    = 1'b0;
        clr_idx_next = clr_idx + ADDR_W'(1);
        if (clr_idx == LAST_A) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          frame_q_next = frame_number;
          if (frame_x < DEPTH_C) begin
            if (frame_x == base_x) begin
              // In-order frame: mark it, advance, and start probing the next entry.
              mem_we           = 1'b1;
              mem_waddr        = ADDR_W'(frame_number);
              window_base_next = base_inc;
              nacked_base_next = '0;
              if (base_inc == DEPTH_B) begin
                pend_kind_next = REPLY_ACK;
                pend_num_next  = REPLY_W'(window_base);
                state_next     = ST_REPLY;
              end else begin
                state_next = ST_WALK;
              end
            end else if (frame_x > base_x) begin
              // Ahead of the base: look up whether it is already buffered.
              mem_raddr  = ADDR_W'(frame_number);
              state_next = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        state_next = ST_IDLE;
        if (!mem_rdata) begin
          mem_we    = 1'b1;
          mem_waddr = ADDR_W'(frame_q);
          if (nacked_base != window_base) begin
            nacked_base_next = window_base;
            pend_kind_next   = REPLY_NACK;
            pend_num_next    = REPLY_W'(window_base);
            state_next       = ST_REPLY;
          end
        end
      end
      ST_WALK: begin
        // Read data belongs to the current base.
        if (mem_rdata) begin
          window_base_next = base_inc;
          if (base_inc == DEPTH_B) begin
            pend_kind_next = REPLY_ACK;
            pend_num_next  = REPLY_W'(window_base);
            state_next     = ST_REPLY;
          end
        end else begin
          pend_kind_next = REPLY_ACK;
          pend_num_next  = REPLY_W'(window_base - BASE_W'(1));
          state_next     = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      window_base <= BASE_W'(1);
      nacked_base <= '0;
      clr_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      window_base <= window_base_next;
      nacked_base <= nacked_base_next;
      clr_idx     <= clr_idx_next;
      // Load the reply register, or drop the entry once the consumer takes it.
      if (state == ST_REPLY && slot_free) begin
        out_valid    <= 1'b1;
        reply_kind   <= pend_kind;
        reply_number <= pend_num;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    frame_q   <= frame_q_next;
    pend_kind <= pend_kind_next;
    pend_num  <= pend_num_next;
  end

  `SRR_ASSERT(a_base_range, clk, rst, (window_base != '0) && (window_base <= DEPTH_B),
              "window base out of range")
  `SRR_ASSERT(a_nack_tracks_base, clk, rst,
              (nacked_base == '0) || (nacked_base == window_base),
              "NACK memory does not match base")
  `SRR_ASSERT_IMPLY(a_nack_nonzero, clk, rst, out_valid && (reply_kind == REPLY_NACK),
                    reply_number != '0, "NACK for frame zero")
  `SRR_ASSERT_IMPLY(a_base_monotonic, clk, rst, !$past(rst),
                    window_base >= $past(window_base), "window base moved backward")

endmodule

`default_nettype wire

FILE: src/srr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module srr_ram #(
  parameter int DEPTH_P = 256,
  parameter int WIDTH   = 1,
  parameter int AW      = $clog2(DEPTH_P)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the selective-repeat receiver: frame stimulus, reply checks.
`default_nettype none

module tb_top;
  import srr_pkg::*;

  // Tracked receiver state: bitmap of arrived frames, window base, last NACKed base.
  typedef struct {
    logic [DEPTH-1:0]  arrived;
    logic [BASE_W-1:0] base;
    logic [BASE_W-1:0] nacked;
  } window_t;

  typedef struct {
    logic               kind;
    logic [REPLY_W-1:0] number;
  } reply_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [FRAME_W-1:0] frame_number = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               reply_kind;
  logic [REPLY_W-1:0] reply_number;

  logic [FRAME_W-1:0] pending_frames[$];  // frames still to be offered to the block
  reply_t             awaited_replies[$]; // predicted replies, oldest first
  window_t            plan_state;         // tracks the stimulus plan while it is built
  window_t            predicted_state;    // tracks the block transaction by transaction
  logic               in_taken   = 1'b0;  // input transaction completed at the last edge
  int                 mismatches = 0;
  int                 cycle_count = 0;

  // Hold both sides free of idling for a long stretch in the middle of the run.
  wire calm = (cycle_count >= 2000) && (cycle_count < 3500);

  selective_repeat_receiver dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_number (frame_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .reply_kind   (reply_kind),
    .reply_number (reply_number)
  );

  always #5 clk = ~clk;

  // Apply one arriving frame to a window state; return 1 when it causes a reply.
  function automatic logic receive_frame(inout window_t st, input logic [FRAME_W-1:0] frame,
                                         output reply_t rep);
    rep.kind   = REPLY_ACK;
    rep.number = '0;
    // Drop frames past the end of the bitmap.
    if (int'(frame) >= DEPTH) return 1'b0;
    if (BASE_W'(frame) == st.base) begin
      // In-order arrival: mark it, walk the base past every buffered frame, clear NACK memory.
      st.arrived[frame] = 1'b1;
      while (st.base < DEPTH && st.arrived[st.base]) st.base++;
      st.nacked  = '0;
      rep.kind   = REPLY_ACK;
      rep.number = REPLY_W'(st.base - 1'b1);
      return 1'b1;
    end
    if (BASE_W'(frame) > st.base && !st.arrived[frame]) begin
      // New frame above the base: buffer it, NACK the base only once per gap.
      st.arrived[frame] = 1'b1;
      if (st.nacked != st.base) begin
        st.nacked  = st.base;
        rep.kind   = REPLY_NACK;
        rep.number = REPLY_W'(st.base);
        return 1'b1;
      end
    end
    // Stale and duplicate frames fall through with no reply.
    return 1'b0;
  endfunction

  // Queue a frame for the driver and advance the planning state with it.
  task automatic plan_frame(input logic [FRAME_W-1:0] frame);
    reply_t unused;
    void'(receive_frame(plan_state, frame, unused));
    pending_frames.push_back(frame);
  endtask

  // Driver: change inputs at the falling edge; hold a payload until its transaction completes.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_frames.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
        in_valid     <= 1'b1;
        frame_number <= pending_frames.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 15);
  end

  // Monitor: sample at the rising edge, predict on each accepted frame, check each reply.
  always @(posedge clk) begin : check_replies
    reply_t want;
    reply_t next_reply;
    cycle_count <= cycle_count + 1;
    in_taken    <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      if (receive_frame(predicted_state, frame_number, next_reply))
        awaited_replies.push_back(next_reply);
    end
    if (!rst && out_valid && !out_stall) begin
      if (awaited_replies.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected reply at cycle %0d: kind %0d number %0d",
                   cycle_count, reply_kind, reply_number);
        mismatches++;
      end else begin
        want = awaited_replies.pop_front();
        if (reply_kind !== want.kind || reply_number !== want.number) begin
          if (mismatches < 10)
            $display("reply mismatch at cycle %0d: kind exp %0d got %0d, number exp %0d got %0d",
                     cycle_count, want.kind, reply_kind, want.number, reply_number);
          mismatches++;
        end
      end
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    logic [FRAME_W-1:0] directed [12];
    int                 r;
    int                 span;
    int                 budget;
    logic [FRAME_W-1:0] f;

    plan_state.arrived      = '0;
    plan_state.base         = BASE_W'(1);
    plan_state.nacked       = '0;
    predicted_state.arrived = '0;
    predicted_state.base    = BASE_W'(1);
    predicted_state.nacked  = '0;

    // Directed opening: frame 0 is stale, top frame buffered then duplicated, a repeated gap
    // stays silent, in-order arrivals walk the base past buffered frames.
    directed = '{8'd0, 8'd255, 8'd255, 8'd3, 8'd1, 8'd2, 8'd5, 8'd4, 8'd1, 8'd7, 8'd8, 8'd6};
    foreach (directed[i]) plan_frame(directed[i]);

    // Random part: mostly frames in a small window at the base, plus stale frames and
    // frames anywhere in the range. Once the base has hit the end, every frame is stale.
    budget = 1090;
    while (budget > 0) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        f = FRAME_W'($urandom_range(0, DEPTH - 1));
      end else if (r < 22) begin
        f = FRAME_W'($urandom_range(0, int'(plan_state.base) - 1));
      end else begin
        span = $urandom_range(1, 12);
        r    = int'(plan_state.base) + $urandom_range(0, span);
        f    = FRAME_W'((r > DEPTH - 1) ? DEPTH - 1 : r);
      end
      plan_frame(f);
      budget--;
    end

    // Fill every remaining gap from the top down so the base walks all the way to the end.
    for (int j = DEPTH - 1; j >= int'(plan_state.base); j--)
      if (!plan_state.arrived[j]) plan_frame(FRAME_W'(j));

    // With the base at the end, every frame is stale.
    plan_frame('0);
    plan_frame('1);
    repeat (40) plan_frame(FRAME_W'($urandom_range(0, DEPTH - 1)));

    // Hold reset, then release it at a falling edge; the block runs its clearing pass
    // with in_stall high, and the driver simply waits on the handshake.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every frame accepted, every predicted reply seen, then cover the longest walk.
    while (pending_frames.size() != 0 || in_valid) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
